// ----- rtl/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// SOME/IP header parser package
// Shared header record, status codes, message type codes and frame limits.
// ----------------------------------------------------------------------------
package shp_pkg;

  // Frame byte limit; the byte counter saturates here
  localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;
  // Fixed SOME/IP header size in bytes
  localparam logic [15:0] HDR_BYTES       = 16'd16;
  // Smallest legal length field (request id plus version and type words)
  localparam logic [31:0] LEN_BASE        = 32'd8;
  // Only supported protocol version
  localparam logic [7:0]  PROTO_VER_OK    = 8'h01;

  // Known message types
  localparam logic [7:0]  MT_REQUEST      = 8'h00;
  localparam logic [7:0]  MT_REQ_NO_RET   = 8'h01;
  localparam logic [7:0]  MT_NOTIFICATION = 8'h02;
  localparam logic [7:0]  MT_RESPONSE     = 8'h80;
  localparam logic [7:0]  MT_ERROR        = 8'h81;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_BAD_TYPE  = 3'd4
  } status_e;

  // Header fields as collected, plus the frame byte count
  typedef struct packed {
    logic [15:0] service;
    logic [15:0] method;
    logic [31:0] length;
    logic [15:0] client;
    logic [15:0] session;
    logic [7:0]  proto;
    logic [7:0]  iface;
    logic [7:0]  mtype;
    logic [7:0]  retc;
    logic [15:0] count;
  } hdr_t;

  function automatic logic type_known(input logic [7:0] t);
    return (t == MT_REQUEST) || (t == MT_REQ_NO_RET) || (t == MT_NOTIFICATION) ||
           (t == MT_RESPONSE) || (t == MT_ERROR);
  endfunction

endpackage

// ----- rtl/shp_in_stage.sv -----
// ----------------------------------------------------------------------------
// SOME/IP header parser input stage
// Registers one incoming byte request; a final byte waits for a free result slot.
// ----------------------------------------------------------------------------
module shp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       res_free_i,
  output logic       step_o,
  output logic [7:0] byte_o,
  output logic       last_o
);
  import shp_pkg::*;

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  // Advance a held byte; a final byte needs the result register free
  assign take       = valid_q && (!last_q || res_free_i);
  assign in_ready_o = !valid_q || take;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until the next accepted request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign step_o = take;
  assign byte_o = byte_q;
  assign last_o = last_q;

  // A held byte that is not final never blocks the input
  a_nonlast_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |-> in_ready_o)
    else $error("input stalled behind a non-final byte");

endmodule

// ----- rtl/shp_collect.sv -----
// ----------------------------------------------------------------------------
// SOME/IP header parser field collector
// Counts frame bytes and shifts header bytes into their fields.
// ----------------------------------------------------------------------------
module shp_collect (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output shp_pkg::hdr_t upd_o,
  output logic          done_o
);
  import shp_pkg::*;

  hdr_t hdr_q;
  hdr_t hdr_d;
  hdr_t upd;

  // Apply the incoming byte to the header record
  always_comb begin
    upd = hdr_q;
    if (hdr_q.count < MAX_FRAME_BYTES) begin
      upd.count = hdr_q.count + 16'd1;
      if (hdr_q.count < HDR_BYTES) begin
        case (hdr_q.count[3:0])
          4'd0, 4'd1:             upd.service = {hdr_q.service[7:0], byte_i};
          4'd2, 4'd3:             upd.method  = {hdr_q.method[7:0], byte_i};
          4'd4, 4'd5, 4'd6, 4'd7: upd.length  = {hdr_q.length[23:0], byte_i};
          4'd8, 4'd9:             upd.client  = {hdr_q.client[7:0], byte_i};
          4'd10, 4'd11:           upd.session = {hdr_q.session[7:0], byte_i};
          4'd12:                  upd.proto   = byte_i;
          4'd13:                  upd.iface   = byte_i;
          4'd14:                  upd.mtype   = byte_i;
          4'd15:                  upd.retc    = byte_i;
          default:                upd = hdr_q;
        endcase
      end
    end
  end

  // Clear everything once the frame ends
  always_comb begin
    hdr_d = hdr_q;
    if (step_i) begin
      hdr_d = last_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
    end else begin
      hdr_q <= hdr_d;
    end
  end

  assign upd_o  = upd;
  assign done_o = step_i && last_i;

  // Frame end leaves a clean record
  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> hdr_q == '0)
    else $error("header record not cleared at frame end");

  // The counter moves by one at most and never wraps
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i |=> hdr_q.count != 16'd0)
    else $error("byte counter wrapped");

endmodule

// ----- rtl/shp_result.sv -----
// ----------------------------------------------------------------------------
// SOME/IP header parser result stage
// Checks the finished header and holds one result request for the consumer.
// ----------------------------------------------------------------------------
module shp_result (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          done_i,
  input  shp_pkg::hdr_t hdr_i,
  output logic          res_free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [15:0]   service_code_o,
  output logic [15:0]   method_code_o,
  output logic [31:0]   declared_length_o,
  output logic [15:0]   client_code_o,
  output logic [15:0]   session_code_o,
  output logic [7:0]    interface_version_o,
  output logic [7:0]    message_type_o,
  output logic [7:0]    ret_code_o,
  output logic [15:0]   payload_available_o
);
  import shp_pkg::*;

  logic        valid_q;
  logic        valid_d;
  status_e     status_q;
  status_e     status_d;
  hdr_t        fields_q;
  hdr_t        fields_d;
  logic [15:0] avail;
  logic [32:0] len_limit;
  logic        trunc;
  logic        bad_len;

  assign res_free_o = !valid_q || out_ready_i;

  // Classify the frame; first failing check wins
  always_comb begin
    trunc     = hdr_i.count < HDR_BYTES;
    avail     = hdr_i.count - HDR_BYTES;
    len_limit = {17'd0, avail} + {1'b0, LEN_BASE};
    bad_len   = (hdr_i.length < LEN_BASE) || ({1'b0, hdr_i.length} > len_limit);
    fields_d  = hdr_i;
    fields_d.count = avail;
    if (trunc) begin
      status_d = ST_TRUNCATED;
      fields_d = '0;
    end else if (bad_len) begin
      status_d = ST_BAD_LEN;
    end else if (hdr_i.proto != PROTO_VER_OK) begin
      status_d = ST_BAD_VER;
    end else if (!type_known(hdr_i.mtype)) begin
      status_d = ST_BAD_TYPE;
    end else begin
      status_d = ST_OK;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (done_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new result only when the frame ends
  always_ff @(posedge clk_i) begin
    if (done_i) begin
      status_q <= status_d;
      fields_q <= fields_d;
    end
  end

  assign out_valid_o         = valid_q;
  assign status_o            = status_q;
  assign service_code_o      = fields_q.service;
  assign method_code_o       = fields_q.method;
  assign declared_length_o   = fields_q.length;
  assign client_code_o       = fields_q.client;
  assign session_code_o      = fields_q.session;
  assign interface_version_o = fields_q.iface;
  assign message_type_o      = fields_q.mtype;
  assign ret_code_o          = fields_q.retc;
  assign payload_available_o = fields_q.count;

  // A frame end never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> res_free_o)
    else $error("result overwritten before it was taken");

  // Truncated frames report no header fields
  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_TRUNCATED |-> fields_q == '0)
    else $error("truncated result carries header data");

  // A good frame declares a length that the payload covers
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_OK |->
      {1'b0, fields_q.length} <= {17'd0, fields_q.count} + {1'b0, LEN_BASE})
    else $error("ok result with inconsistent length");

endmodule

// ----- rtl/someip_header_parser_top.sv -----
// out_valid_o rises when the result register loads a frame's final byte from the
//   input register; an unread result keeps that byte waiting there.
// Throughput: one byte per cycle; only a final byte waits, and only while the
//   previous result sits unread in the result register.
// Reset clears the byte counter, the header record and both valid flags.
// ----------------------------------------------------------------------------
// SOME/IP header parser top level
// Collects the 16-byte header of each frame and reports fields and status.
// ----------------------------------------------------------------------------
module someip_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] service_code_o,
  output logic [15:0] method_code_o,
  output logic [31:0] declared_length_o,
  output logic [15:0] client_code_o,
  output logic [15:0] session_code_o,
  output logic [7:0]  interface_version_o,
  output logic [7:0]  message_type_o,
  output logic [7:0]  ret_code_o,
  output logic [15:0] payload_available_o
);
  import shp_pkg::*;

  logic       res_free;
  logic       step;
  logic [7:0] byte_s;
  logic       last_s;
  hdr_t       upd;
  logic       done;

  // Register incoming byte requests
  shp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_free_i  (res_free),
    .step_o      (step),
    .byte_o      (byte_s),
    .last_o      (last_s)
  );

  // Collect header fields and count bytes
  shp_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_s),
    .last_i (last_s),
    .upd_o  (upd),
    .done_o (done)
  );

  // Check the header and hold the result
  shp_result u_result (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .done_i              (done),
    .hdr_i               (upd),
    .res_free_o          (res_free),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .service_code_o      (service_code_o),
    .method_code_o       (method_code_o),
    .declared_length_o   (declared_length_o),
    .client_code_o       (client_code_o),
    .session_code_o      (session_code_o),
    .interface_version_o (interface_version_o),
    .message_type_o      (message_type_o),
    .ret_code_o          (ret_code_o),
    .payload_available_o (payload_available_o)
  );

endmodule
